### rtl/core/bir_pkg.sv
// shared types and constants for the binaural itd/ild renderer
package bir_pkg;

    localparam int DELAY_DEPTH_DEF = 128;
    localparam int SAMPLE_BITS_DEF = 16;

    // depth of the request queue between front and back
    localparam int Q_DEPTH = 2;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;

    localparam logic [CFG_IDX_W-1:0] CFG_ITD_DELAY    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LP_ALPHA     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FAR_EAR_LEFT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_LEFT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_RIGHT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_RAMP_RECIP   = 3'd5;

    localparam logic [6:0]  ITD_DELAY_RST  = 7'd0;
    localparam logic [15:0] LP_ALPHA_RST   = 16'd32768;
    localparam logic        FAR_LEFT_RST   = 1'b0;
    localparam logic [15:0] TARGET_RST     = 16'd4096;
    localparam logic [16:0] RAMP_RECIP_RST = 17'd256;

    localparam logic [15:0] ALPHA_ONE = 16'd32768;
    localparam logic [16:0] RECIP_ONE = 17'd65536;

    typedef struct packed {
        logic [6:0]  itd_delay;
        logic [15:0] lp_alpha;
        logic        far_ear_left;
        logic [15:0] target_left_gain;
        logic [15:0] target_right_gain;
        logic [16:0] ramp_recip;
    } t_cfg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_STEP_L,
        S_STEP_R,
        S_STEP_W,
        S_FILT,
        S_ACC,
        S_FAR,
        S_OUT
    } t_back_state;

endpackage

### rtl/core/bir_ram.sv
// generic single-write, single-read ram with registered read data
module bir_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/core/bir_queue.sv
// short fifo that decouples the front from the back
module bir_queue #(
    parameter int WIDTH = 34,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic [WIDTH-1:0] i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output logic [WIDTH-1:0] o_out_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_buf [DEPTH];
    logic [PW-1:0]    r_wr_ptr;
    logic [PW-1:0]    r_rd_ptr;
    logic [CW-1:0]    r_count;
    logic             push;
    logic             pop;

    assign o_in_ready  = (r_count != CW'(DEPTH));
    assign o_out_valid = (r_count != '0);
    assign o_out_data  = r_buf[r_rd_ptr];
    assign push        = i_in_valid && o_in_ready;
    assign pop         = o_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_buf[r_wr_ptr] <= i_in_data;
        end
    end

endmodule

### rtl/core/bir_front.sv
// front end: writes samples to the delay store, fetches the far-ear tap, tags block starts
module bir_front import bir_pkg::*; #(
    parameter int DELAY_DEPTH = DELAY_DEPTH_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [SAMPLE_BITS-1:0]     i_sample,
    input  logic                       i_last,
    input  logic [6:0]                 i_itd_delay,
    output logic                       o_push_valid,
    input  logic                       i_push_ready,
    output logic [2*SAMPLE_BITS+1:0]   o_push_data
);

    localparam int AW = $clog2(DELAY_DEPTH);
    localparam int SW = AW + 1;
    localparam int DW = (AW + 1 > 8) ? AW + 1 : 8;

    logic [AW-1:0]          r_wp;
    logic                   r_wrapped;
    logic                   r_blk_start;
    logic                   r_stg_valid;
    logic [SAMPLE_BITS-1:0] r_stg_x;
    logic                   r_stg_last;
    logic                   r_stg_start;
    logic                   r_stg_byp;
    logic                   r_stg_ok;

    logic [DW-1:0]          dly_mod;
    logic [AW-1:0]          dly;
    logic [SW-1:0]          rd_sum;
    logic [AW-1:0]          rd_addr;
    logic                   wp_last;
    logic                   accept;
    logic [SAMPLE_BITS-1:0] rd_data;
    logic [SAMPLE_BITS-1:0] far_val;

    assign o_ready = !r_stg_valid || i_push_ready;
    assign accept  = i_valid && o_ready;
    assign wp_last = (r_wp == AW'(DELAY_DEPTH - 1));

    // delay wraps modulo the store depth (for depths of 26 or more), then tap = wp - delay
    always_comb begin
        dly_mod = DW'(i_itd_delay);
        for (int k = 0; k < 4; k++) begin
            if (dly_mod >= DW'(DELAY_DEPTH)) begin
                dly_mod = dly_mod - DW'(DELAY_DEPTH);
            end
        end
        dly    = dly_mod[AW-1:0];
        rd_sum = {1'b0, r_wp} + SW'(DELAY_DEPTH) - {1'b0, dly};
        if (rd_sum >= SW'(DELAY_DEPTH)) begin
            rd_sum = rd_sum - SW'(DELAY_DEPTH);
        end
        rd_addr = rd_sum[AW-1:0];
    end

    bir_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (DELAY_DEPTH)
    ) u_delay_ram (
        .i_clk   (i_clk),
        .i_we    (accept),
        .i_waddr (r_wp),
        .i_wdata (i_sample),
        .i_re    (accept),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp        <= '0;
            r_wrapped   <= 1'b0;
            r_blk_start <= 1'b1;
            r_stg_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_wp        <= wp_last ? '0 : r_wp + 1'b1;
                r_blk_start <= i_last;
                r_stg_valid <= 1'b1;
                if (wp_last) begin
                    r_wrapped <= 1'b1;
                end
            end else if (i_push_ready) begin
                r_stg_valid <= 1'b0;
            end
        end
    end

    // entries not yet written since reset read as zero
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_stg_x     <= i_sample;
            r_stg_last  <= i_last;
            r_stg_start <= r_blk_start;
            r_stg_byp   <= (dly == '0);
            r_stg_ok    <= r_wrapped || (rd_addr <= r_wp);
        end
    end

    assign far_val      = r_stg_byp ? r_stg_x : (r_stg_ok ? rd_data : '0);
    assign o_push_valid = r_stg_valid;
    assign o_push_data  = {r_stg_start, r_stg_last, far_val, r_stg_x};

endmodule

### rtl/core/bir_back.sv
// back end: gain ramps, head-shadow low-pass and output scaling on one shared multiplier
module bir_back import bir_pkg::*; #(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  t_cfg                           i_cfg,
    input  logic                           i_pop_valid,
    output logic                           o_pop_ready,
    input  logic [2*SAMPLE_BITS+1:0]       i_pop_data,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic signed [SAMPLE_BITS-1:0]  o_left,
    output logic signed [SAMPLE_BITS-1:0]  o_right
);

    localparam int SB     = SAMPLE_BITS;
    localparam int AB     = SAMPLE_BITS + 8;
    localparam int MA     = (AB + 1 > 34) ? AB + 1 : 34;
    localparam int MB     = 18;
    localparam int PW     = MA + MB;
    localparam int GAIN_W = 32;
    localparam int STEP_W = 33;

    localparam logic signed [PW-1:0] RND_TZ   = PW'(65535);
    localparam logic signed [PW-1:0] RND_FILT = PW'(16384);
    localparam logic signed [PW-1:0] RND_NEAR = PW'(2048);
    localparam logic signed [PW-1:0] RND_FAR  = PW'(524288);

    localparam logic [SB-1:0] OUT_MAX = {1'b0, {(SB - 1){1'b1}}};
    localparam logic [SB-1:0] OUT_MIN = {1'b1, {(SB - 1){1'b0}}};
    localparam logic [AB-1:0] ACC_MAX = {1'b0, {(AB - 1){1'b1}}};
    localparam logic [AB-1:0] ACC_MIN = {1'b1, {(AB - 1){1'b0}}};

    t_back_state              r_state;
    t_back_state              n_state;
    logic                     r_primed;
    logic signed [AB-1:0]     r_acc;
    logic [GAIN_W-1:0]        r_gain_l;
    logic [GAIN_W-1:0]        r_gain_r;
    logic signed [STEP_W-1:0] r_step_l;
    logic signed [STEP_W-1:0] r_step_r;
    logic signed [SB-1:0]     r_x;
    logic [SB-1:0]            r_farv;
    logic                     r_last;
    logic signed [PW-1:0]     r_prod;
    logic [SB-1:0]            r_near;
    logic                     r_out_valid;
    logic [SB-1:0]            r_out_left;
    logic [SB-1:0]            r_out_right;

    logic [SB-1:0]            head_x;
    logic [SB-1:0]            head_farv;
    logic                     head_last;
    logic                     head_start;
    logic                     pop;
    logic                     out_load;
    logic [15:0]              alpha_c;
    logic [16:0]              recip_c;
    logic [SB-1:0]            fv_src;
    logic signed [AB:0]       fdiff;
    logic signed [33:0]       diff_l;
    logic signed [33:0]       diff_r;
    logic [15:0]              g12_near;
    logic [15:0]              g12_far;
    logic [GAIN_W-1:0]        adv_l;
    logic [GAIN_W-1:0]        adv_r;
    logic signed [MA-1:0]     mul_a;
    logic signed [MB-1:0]     mul_b;
    logic signed [PW-1:0]     prod;
    logic signed [PW-1:0]     step_sh;
    logic signed [PW-1:0]     inc_sh;
    logic [AB+1:0]            acc_sum;
    logic signed [AB-1:0]     acc_new;
    logic signed [PW-1:0]     near_sh;
    logic signed [PW-1:0]     far_sh;
    logic [SB-1:0]            near_sat;
    logic [SB-1:0]            far_sat;

    function automatic logic [GAIN_W-1:0] gain_adv(input logic [GAIN_W-1:0] g,
                                                   input logic signed [STEP_W-1:0] s);
        logic signed [GAIN_W+1:0] sum;
        sum = $signed({2'b00, g}) + (GAIN_W + 2)'(s);
        if (sum[GAIN_W+1]) begin
            return '0;
        end else if (sum[GAIN_W]) begin
            return '1;
        end
        return sum[GAIN_W-1:0];
    endfunction

    assign head_x      = i_pop_data[SB-1:0];
    assign head_farv   = i_pop_data[2*SB-1:SB];
    assign head_last   = i_pop_data[2*SB];
    assign head_start  = i_pop_data[2*SB+1];
    assign o_pop_ready = (r_state == S_IDLE);
    assign pop         = i_pop_valid && o_pop_ready;
    assign out_load    = (r_state == S_OUT) && (!r_out_valid || i_out_ready);

    assign alpha_c = (i_cfg.lp_alpha > ALPHA_ONE) ? ALPHA_ONE : i_cfg.lp_alpha;
    assign recip_c = (i_cfg.ramp_recip > RECIP_ONE) ? RECIP_ONE : i_cfg.ramp_recip;

    assign fv_src = (r_state == S_IDLE) ? head_farv : r_farv;
    assign fdiff  = $signed({fv_src[SB-1], fv_src, 8'h00}) - $signed({r_acc[AB-1], r_acc});
    assign diff_l = $signed({2'b00, i_cfg.target_left_gain, 16'h0000})
                  - $signed({2'b00, r_gain_l});
    assign diff_r = $signed({2'b00, i_cfg.target_right_gain, 16'h0000})
                  - $signed({2'b00, r_gain_r});

    assign g12_near = i_cfg.far_ear_left ? r_gain_r[GAIN_W-1:16] : r_gain_l[GAIN_W-1:16];
    assign g12_far  = i_cfg.far_ear_left ? r_gain_l[GAIN_W-1:16] : r_gain_r[GAIN_W-1:16];
    assign adv_l    = gain_adv(r_gain_l, r_step_l);
    assign adv_r    = gain_adv(r_gain_r, r_step_r);

    // one multiplier, operands picked by the sequencer
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_IDLE, S_FILT: begin
                mul_a = MA'(fdiff);
                mul_b = $signed({2'b00, alpha_c});
            end
            S_STEP_L: begin
                mul_a = MA'(diff_l);
                mul_b = $signed({1'b0, recip_c});
            end
            S_STEP_R: begin
                mul_a = MA'(diff_r);
                mul_b = $signed({1'b0, recip_c});
            end
            S_ACC: begin
                mul_a = MA'(r_x);
                mul_b = $signed({2'b00, g12_near});
            end
            S_FAR: begin
                mul_a = MA'(r_acc);
                mul_b = $signed({2'b00, g12_far});
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod = mul_a * mul_b;

    // step is truncated toward zero
    always_comb begin
        step_sh = r_prod;
        if (r_prod[PW-1]) begin
            step_sh = r_prod + RND_TZ;
        end
        step_sh = step_sh >>> 16;
    end

    always_comb begin
        inc_sh  = (r_prod + RND_FILT) >>> 15;
        acc_sum = (AB + 2)'(r_acc) + inc_sh[AB+1:0];
        if (&acc_sum[AB+1:AB-1] || ~|acc_sum[AB+1:AB-1]) begin
            acc_new = acc_sum[AB-1:0];
        end else begin
            acc_new = acc_sum[AB+1] ? ACC_MIN : ACC_MAX;
        end
    end

    always_comb begin
        near_sh = (r_prod + RND_NEAR) >>> 12;
        far_sh  = (r_prod + RND_FAR) >>> 20;
        if (&near_sh[PW-1:SB-1] || ~|near_sh[PW-1:SB-1]) begin
            near_sat = near_sh[SB-1:0];
        end else begin
            near_sat = near_sh[PW-1] ? OUT_MIN : OUT_MAX;
        end
        if (&far_sh[PW-1:SB-1] || ~|far_sh[PW-1:SB-1]) begin
            far_sat = far_sh[SB-1:0];
        end else begin
            far_sat = far_sh[PW-1] ? OUT_MIN : OUT_MAX;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_pop_valid) begin
                    n_state = head_start ? S_STEP_L : S_ACC;
                end
            end
            S_STEP_L: n_state = S_STEP_R;
            S_STEP_R: n_state = S_STEP_W;
            S_STEP_W: n_state = S_FILT;
            S_FILT:   n_state = S_ACC;
            S_ACC:    n_state = S_FAR;
            S_FAR:    n_state = S_OUT;
            S_OUT: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_primed    <= 1'b0;
            r_acc       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (pop && head_start) begin
                r_primed <= 1'b1;
            end
            if (r_state == S_ACC) begin
                r_acc <= acc_new;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state != S_OUT) begin
            r_prod <= prod;
        end
        if (pop) begin
            r_x    <= head_x;
            r_farv <= head_farv;
            r_last <= head_last;
        end
        case (r_state)
            S_IDLE: begin
                if (pop) begin
                    if (head_start) begin
                        if (!r_primed) begin
                            r_gain_l <= {i_cfg.target_left_gain, 16'h0000};
                            r_gain_r <= {i_cfg.target_right_gain, 16'h0000};
                        end
                    end else begin
                        r_gain_l <= adv_l;
                        r_gain_r <= adv_r;
                    end
                end
            end
            S_STEP_R: r_step_l <= step_sh[STEP_W-1:0];
            S_STEP_W: r_step_r <= step_sh[STEP_W-1:0];
            S_FILT: begin
                r_gain_l <= adv_l;
                r_gain_r <= adv_r;
            end
            S_FAR: r_near <= near_sat;
            S_OUT: begin
                // gains snap to target after the last sample of a block
                if (out_load && r_last) begin
                    r_gain_l <= {i_cfg.target_left_gain, 16'h0000};
                    r_gain_r <= {i_cfg.target_right_gain, 16'h0000};
                end
            end
            default: ;
        endcase
        if (out_load) begin
            r_out_left  <= i_cfg.far_ear_left ? far_sat : r_near;
            r_out_right <= i_cfg.far_ear_left ? r_near : far_sat;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_left      = r_out_left;
    assign o_right     = r_out_right;

endmodule

### rtl/core/binaural_itd_ild_renderer.sv
// top level of the binaural itd/ild renderer
// Takes one mono sample per request and returns one stereo pair per request, in order. The
// near ear gets the current sample, the far ear the sample delayed by itd_delay and low-passed,
// and both are scaled by gains ramping over the block toward the targets. A front end writes
// the delay store and fetches the far tap; a two-entry queue feeds the back end, which runs
// everything on one shared 34x18 multiplier (wider for sample widths above 25): the first
// sample of a block also passes the gain step states there, since the two gain steps are
// computed on the same multiplier. The delay store needs no clearing pass after reset:
// unwritten entries are tracked by the write pointer and read as zero. Configuration writes
// belong to idle periods only.
module binaural_itd_ild_renderer import bir_pkg::*; #(
    parameter int DELAY_DEPTH = DELAY_DEPTH_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    localparam int IN_W       = ((SAMPLE_BITS + 7) / 8) * 8,
    localparam int OUT_W      = ((2 * SAMPLE_BITS + 7) / 8) * 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_W-1:0]       s_axis_tdata,   // mono_sample
    input  logic                  s_axis_tlast,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_W-1:0]      m_axis_tdata,   // left_sample, right_sample
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int QW = 2 * SAMPLE_BITS + 2;

    t_cfg                   r_cfg;
    logic                   push_valid;
    logic                   push_ready;
    logic [QW-1:0]          push_data;
    logic                   pop_valid;
    logic                   pop_ready;
    logic [QW-1:0]          pop_data;
    logic [SAMPLE_BITS-1:0] left_sample;
    logic [SAMPLE_BITS-1:0] right_sample;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.itd_delay         <= ITD_DELAY_RST;
            r_cfg.lp_alpha          <= LP_ALPHA_RST;
            r_cfg.far_ear_left      <= FAR_LEFT_RST;
            r_cfg.target_left_gain  <= TARGET_RST;
            r_cfg.target_right_gain <= TARGET_RST;
            r_cfg.ramp_recip        <= RAMP_RECIP_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ITD_DELAY:    r_cfg.itd_delay         <= i_cfg_data[6:0];
                CFG_LP_ALPHA:     r_cfg.lp_alpha          <= i_cfg_data[15:0];
                CFG_FAR_EAR_LEFT: r_cfg.far_ear_left      <= i_cfg_data[0];
                CFG_TARGET_LEFT:  r_cfg.target_left_gain  <= i_cfg_data[15:0];
                CFG_TARGET_RIGHT: r_cfg.target_right_gain <= i_cfg_data[15:0];
                CFG_RAMP_RECIP:   r_cfg.ramp_recip        <= i_cfg_data[16:0];
                default: ;
            endcase
        end
    end

    bir_front #(
        .DELAY_DEPTH (DELAY_DEPTH),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (s_axis_tvalid),
        .o_ready      (s_axis_tready),
        .i_sample     (s_axis_tdata[SAMPLE_BITS-1:0]),
        .i_last       (s_axis_tlast),
        .i_itd_delay  (r_cfg.itd_delay),
        .o_push_valid (push_valid),
        .i_push_ready (push_ready),
        .o_push_data  (push_data)
    );

    bir_queue #(
        .WIDTH (QW),
        .DEPTH (Q_DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (push_valid),
        .o_in_ready  (push_ready),
        .i_in_data   (push_data),
        .o_out_valid (pop_valid),
        .i_out_ready (pop_ready),
        .o_out_data  (pop_data)
    );

    bir_back #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_pop_valid (pop_valid),
        .o_pop_ready (pop_ready),
        .i_pop_data  (pop_data),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_left      (left_sample),
        .o_right     (right_sample)
    );

    assign m_axis_tdata = OUT_W'({right_sample, left_sample});

endmodule

### rtl/core/bir_checker.sv
// port-level checker for the renderer, bound to the top level
module bir_checker import bir_pkg::*; #(
    parameter int OUT_W = 32
) (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             s_axis_tvalid,
    input logic             s_axis_tready,
    input logic             m_axis_tvalid,
    input logic             m_axis_tready,
    input logic [OUT_W-1:0] m_axis_tdata
);

    // front stage, queue, back end and output register
    localparam int MAX_PEND = Q_DEPTH + 3;

    logic [3:0] r_pending;
    logic       in_acc;
    logic       out_acc;

    assign in_acc  = s_axis_tvalid && s_axis_tready;
    assign out_acc = m_axis_tvalid && m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
        end else begin
            r_pending <= r_pending + 4'(in_acc) - 4'(out_acc);
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed or dropped while stalled");

    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid && s_axis_tready)
        else $error("wrong port state after reset");

    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> r_pending != 4'd0)
        else $error("result shown with no request outstanding");

    a_full_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pending == 4'(MAX_PEND) |-> !s_axis_tready)
        else $error("request taken with every stage full");

endmodule

bind binaural_itd_ild_renderer bir_checker #(
    .OUT_W (OUT_W)
) u_bir_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

### dv/bir_render_sb_pkg.sv
// scoreboard class and predictor for the binaural renderer testbench
`timescale 1ns / 100ps
package bir_render_sb_pkg;
    import bir_pkg::*;

    localparam int    TAP_DEPTH = DELAY_DEPTH_DEF;
    localparam longint GAIN_MAX = 64'h0000_0000_FFFF_FFFF;
    localparam int    MAX_REPORTS = 20;

    typedef struct packed {
        logic [15:0] right;
        logic [15:0] left;
    } stereo_pair_t;

    class bir_render_scoreboard;
        // register copies
        longint itd_delay, lp_alpha, far_left, tgt_left, tgt_right, ramp_recip;
        // renderer state
        longint taps [TAP_DEPTH];
        int     wr_ptr;
        longint shadow_acc;
        longint gain_left, gain_right, step_left, step_right;
        bit     block_start, primed;

        stereo_pair_t pending_pairs [$];
        int errors, pairs_checked, requests, blocks, clipped;

        function new();
            itd_delay  = ITD_DELAY_RST;
            lp_alpha   = LP_ALPHA_RST;
            far_left   = FAR_LEFT_RST;
            tgt_left   = TARGET_RST;
            tgt_right  = TARGET_RST;
            ramp_recip = RAMP_RECIP_RST;
            foreach (taps[i]) taps[i] = 0;
            wr_ptr = 0;
            shadow_acc = 0;
            gain_left = 0;
            gain_right = 0;
            step_left = 0;
            step_right = 0;
            block_start = 1;
            primed = 0;
            errors = 0;
            pairs_checked = 0;
            requests = 0;
            blocks = 0;
            clipped = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_ITD_DELAY:    itd_delay  = val[6:0];
                CFG_LP_ALPHA:     lp_alpha   = val[15:0];
                CFG_FAR_EAR_LEFT: far_left   = val[0];
                CFG_TARGET_LEFT:  tgt_left   = val[15:0];
                CFG_TARGET_RIGHT: tgt_right  = val[15:0];
                CFG_RAMP_RECIP:   ramp_recip = val[16:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return pending_pairs.size();
        endfunction

        function longint clip(longint v, int bits);
            longint hi;
            hi = (longint'(1) << (bits - 1)) - 1;
            if (v > hi) return hi;
            if (v < -hi - 1) return -hi - 1;
            return v;
        endfunction

        // signed division truncates toward zero, as the ramp step requires
        function longint ramp_step(longint target, longint now, longint recip);
            return (((target << 16) - now) * recip) / 65536;
        endfunction

        function longint ramp_gain(longint now, longint step);
            longint g;
            g = now + step;
            if (g < 0) return 0;
            if (g > GAIN_MAX) return GAIN_MAX;
            return g;
        endfunction

        function logic [15:0] apply_gain(longint v, longint gain_q428, int frac);
            longint r;
            r = (v * (gain_q428 >>> 16) + (longint'(1) << (frac - 1))) >>> frac;
            r = clip(r, 16);
            if (r == 32767 || r == -32768) clipped++;
            return r[15:0];
        endfunction

        function void take_request(logic signed [15:0] sample, bit last);
            longint x, recip, alpha, far_tap;
            int d;
            stereo_pair_t pair;
            x = sample;
            recip = (ramp_recip > 65536) ? 65536 : ramp_recip;
            alpha = (lp_alpha > 32768) ? 32768 : lp_alpha;
            d = itd_delay % TAP_DEPTH;
            requests++;

            if (block_start) begin
                if (!primed) begin
                    gain_left  = tgt_left << 16;
                    gain_right = tgt_right << 16;
                    primed = 1;
                end
                step_left  = ramp_step(tgt_left, gain_left, recip);
                step_right = ramp_step(tgt_right, gain_right, recip);
                block_start = 0;
            end

            taps[wr_ptr] = x;
            far_tap = taps[(wr_ptr + TAP_DEPTH - d) % TAP_DEPTH];
            wr_ptr = (wr_ptr + 1) % TAP_DEPTH;

            // head shadow low-pass, accumulator carries 8 extra fraction bits
            shadow_acc = shadow_acc + ((alpha * (far_tap * 256 - shadow_acc) + 16384) >>> 15);
            shadow_acc = clip(shadow_acc, 24);

            gain_left  = ramp_gain(gain_left, step_left);
            gain_right = ramp_gain(gain_right, step_right);

            if (far_left != 0) begin
                pair.left  = apply_gain(shadow_acc, gain_left, 20);
                pair.right = apply_gain(x, gain_right, 12);
            end else begin
                pair.left  = apply_gain(x, gain_left, 12);
                pair.right = apply_gain(shadow_acc, gain_right, 20);
            end
            pending_pairs.push_back(pair);

            if (last) begin
                gain_left  = tgt_left << 16;
                gain_right = tgt_right << 16;
                block_start = 1;
                blocks++;
            end
        endfunction

        function void check_pair(logic [15:0] left, logic [15:0] right);
            stereo_pair_t want;
            if (pending_pairs.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: unexpected result left %0d right %0d", $time,
                             $signed(left), $signed(right));
                return;
            end
            want = pending_pairs.pop_front();
            pairs_checked++;
            if (want.left !== left) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: left_sample mismatch: expected %0d actual %0d", $time,
                             $signed(want.left), $signed(left));
            end
            if (want.right !== right) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: right_sample mismatch: expected %0d actual %0d", $time,
                             $signed(want.right), $signed(right));
            end
        endfunction
    endclass

endpackage

### dv/tb_binaural_itd_ild_renderer.sv
// testbench top for the binaural itd/ild renderer
`timescale 1ns / 100ps
module tb_binaural_itd_ild_renderer;
    import bir_pkg::*;
    import bir_render_sb_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int LONG_HOLD = 400;
    localparam int PHASES = 8;
    localparam int PHASE_ITEMS = 90;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [15:0]           s_axis_tdata = '0;   // mono_sample
    logic                  s_axis_tlast = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [31:0]           m_axis_tdata;        // left_sample, right_sample
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    bir_render_scoreboard sb = new();

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    logic hold_req = 1'b0;
    logic hold_done = 1'b0;
    int hold_left = 0;
    int stall_cycles = 0;
    int settings = 0;
    int blk_left = 0;

    binaural_itd_ild_renderer dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // output side: random stalls plus one long hold-off on request
    always @(posedge i_clk) begin
        if (hold_req && !hold_done) begin
            hold_done <= 1'b1;
            hold_left <= LONG_HOLD;
            m_axis_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_pair(m_axis_tdata[15:0], m_axis_tdata[31:16]);
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles == WATCHDOG_LIMIT) begin
            $display("%0t: timeout, no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic send_item(logic [15:0] sample, bit last);
        while (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= sample;
        s_axis_tlast <= last;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.take_request(sample, last);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        sb.set_reg(idx, val);
    endtask

    task automatic apply_setting(int delay, int alpha, int far_l, int tl, int tr, int recip);
        drain();
        write_reg(CFG_ITD_DELAY, delay);
        write_reg(CFG_LP_ALPHA, alpha);
        write_reg(CFG_FAR_EAR_LEFT, far_l);
        write_reg(CFG_TARGET_LEFT, tl);
        write_reg(CFG_TARGET_RIGHT, tr);
        write_reg(CFG_RAMP_RECIP, recip);
        i_cfg_we <= 1'b0;
        settings++;
    endtask

    function automatic logic [15:0] pick_sample();
        case ($urandom_range(0, 7))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'($signed($urandom_range(0, 128)) - 64);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic int pick_gain();
        case ($urandom_range(0, 3))
            0: return $urandom_range(0, 65535);
            1: return $urandom_range(3800, 4400);
            default: return $urandom_range(0, 8192);
        endcase
    endfunction

    function automatic int pick_alpha();
        case ($urandom_range(0, 5))
            0: return 0;
            1: return ALPHA_ONE;
            2: return $urandom_range(32769, 65535);
            default: return $urandom_range(0, 32768);
        endcase
    endfunction

    task automatic run_phase(int p);
        int nom, delay, recip, i;
        bit last;
        nom = $urandom_range(1, 24);
        recip = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 131071) : 65536 / nom;
        delay = $urandom_range(0, 127);
        if ($urandom_range(0, 3) == 0) delay = ($urandom_range(0, 1) != 0) ? 127 : 0;
        if (p == 0)
            apply_setting(127, 65535, 1, 65535, 65535, 131071);
        else if (p == 1)
            apply_setting(0, 0, 0, 0, 0, 0);
        else
            apply_setting(delay, pick_alpha(), $urandom_range(0, 1), pick_gain(), pick_gain(),
                          recip);
        // idling phases: none, sender idle, receiver stalls, both lightly
        case (p % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct <= 0;  end
            1: begin send_idle_pct = 70; recv_stall_pct <= 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct <= 70; end
            default: begin send_idle_pct = 9; recv_stall_pct <= 9; end
        endcase
        if (p == 4) hold_req <= 1'b1;
        for (i = 0; i < PHASE_ITEMS; i++) begin
            if (blk_left == 0)
                blk_left = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3 * nom) : nom;
            blk_left--;
            last = (blk_left == 0);
            // an occasional block cut short
            if ($urandom_range(0, 99) < 3) begin
                last = 1'b1;
                blk_left = 0;
            end
            if (p == 5 && i == 45) drain();
            send_item(pick_sample(), last);
        end
    endtask

    initial begin
        int i;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // first block runs at reset settings, gains primed from targets
        send_item(16'h7FFF, 0);
        send_item(16'h8000, 0);
        send_item(16'h0000, 0);
        send_item(16'hFFFF, 0);
        send_item(16'h0001, 1);

        // zero delay, alpha and recip above one, left far ear, extreme targets
        apply_setting(0, 65535, 1, 65535, 0, 131071);
        send_item(16'h7FFF, 0);
        send_item(16'h8000, 0);
        send_item(16'h5555, 0);
        send_item(16'hAAAA, 1);

        // longest delay, filter closed, then targets change mid-block
        apply_setting(127, 0, 0, 0, 65535, 8192);
        for (i = 0; i < 6; i++) send_item(pick_sample(), 0);
        drain();
        write_reg(CFG_TARGET_LEFT, 40000);
        write_reg(CFG_TARGET_RIGHT, 1);
        i_cfg_we <= 1'b0;
        for (i = 0; i < 4; i++) send_item(pick_sample(), i == 3);

        // full-scale step over a 4-sample block overshoots the targets
        apply_setting(5, 1, 0, 20000, 3000, 65536);
        for (i = 0; i < 4; i++) send_item(16'h7FFF ^ 16'(i << 15), i == 3);

        for (i = 0; i < PHASES; i++) run_phase(i);

        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        $display("run covered %0d samples in %0d closed blocks under %0d register settings",
                 sb.requests, sb.blocks, settings);
        $display("%0d stereo pairs checked, %0d channel outputs at full scale",
                 sb.pairs_checked, sb.clipped);
        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

### files.f
rtl/core/bir_pkg.sv
rtl/core/bir_ram.sv
rtl/core/bir_queue.sv
rtl/core/bir_front.sv
rtl/core/bir_back.sv
rtl/core/binaural_itd_ild_renderer.sv
rtl/core/bir_checker.sv
dv/bir_render_sb_pkg.sv
dv/tb_binaural_itd_ild_renderer.sv
